@@ sv/lcs_pkg.sv @@
// lcs_pkg: types, codes and reset values shared by the link supervisor files
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

    localparam int unsigned KIND_W   = 4;
    localparam int unsigned NET_W    = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0]  STARTUP_TIMEOUT_RST   = 32'd10000;
    localparam logic [COUNT_W-1:0] ATTEMPT_LIMIT_RST     = 8'd3;
    localparam logic [WORD_W-1:0]  RECONNECT_TIMEOUT_RST = 32'd30000;
    localparam logic [WORD_W-1:0]  PROBE_INTERVAL_RST    = 32'd5000;
    localparam logic [COUNT_W-1:0] FAIL_THRESHOLD_RST    = 8'd3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STARTUP_TIMEOUT   = 3'd0,
        CFG_ATTEMPT_LIMIT     = 3'd1,
        CFG_RECONNECT_TIMEOUT = 3'd2,
        CFG_PROBE_INTERVAL    = 3'd3,
        CFG_FAIL_THRESHOLD    = 3'd4
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_START       = 4'd0,
        KIND_SCAN_SEL    = 4'd1,
        KIND_SCAN_EMPTY  = 4'd2,
        KIND_CONNECTED   = 4'd3,
        KIND_FAILED      = 4'd4,
        KIND_LOST        = 4'd5,
        KIND_HEALTHY     = 4'd6,
        KIND_UNHEALTHY   = 4'd7,
        KIND_HS_UP       = 4'd8,
        KIND_HS_FAIL     = 4'd9,
        KIND_RETRY       = 4'd10,
        KIND_FORCE_HS    = 4'd11,
        KIND_XFER_START  = 4'd12,
        KIND_XFER_END    = 4'd13,
        KIND_TICK        = 4'd14,
        KIND_STOP        = 4'd15
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADARG   = 2'd1,
        ST_BADSTATE = 2'd2,
        ST_LOCKED   = 2'd3
    } t_status;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_SCAN    = 3'd1,
        ACT_CONNECT = 3'd2,
        ACT_RECOVER = 3'd3,
        ACT_HOTSPOT = 3'd4,
        ACT_PROBE   = 3'd5,
        ACT_STOP    = 3'd6
    } t_action;

    // supervisor modes, one-hot
    typedef enum logic [7:0] {
        MODE_STOPPED    = 8'b0000_0001,
        MODE_SEARCHING  = 8'b0000_0010,
        MODE_CONNECTING = 8'b0000_0100,
        MODE_CLIENT     = 8'b0000_1000,
        MODE_RECONNECT  = 8'b0001_0000,
        MODE_HS_START   = 8'b0010_0000,
        MODE_HS_READY   = 8'b0100_0000,
        MODE_FAULTED    = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        logic [WORD_W-1:0]  startup_timeout;
        logic [COUNT_W-1:0] attempt_limit;
        logic [WORD_W-1:0]  reconnect_timeout;
        logic [WORD_W-1:0]  probe_interval;
        logic [COUNT_W-1:0] fail_threshold;
    } t_cfg;

    typedef struct packed {
        t_kind                    kind;
        logic [NET_W-1:0]         net_id;
        logic signed [WORD_W-1:0] err_code;
        logic [WORD_W-1:0]        elapsed;
    } t_event;

    typedef struct packed {
        t_status                  status;
        t_action                  action;
        logic [NET_W-1:0]         action_net_id;
        logic [MODE_W-1:0]        mode_now;
        logic signed [WORD_W-1:0] last_error;
        logic                     transfer_locked;
    } t_result;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            MODE_STOPPED:    c = 3'd0;
            MODE_SEARCHING:  c = 3'd1;
            MODE_CONNECTING: c = 3'd2;
            MODE_CLIENT:     c = 3'd3;
            MODE_RECONNECT:  c = 3'd4;
            MODE_HS_START:   c = 3'd5;
            MODE_HS_READY:   c = 3'd6;
            MODE_FAULTED:    c = 3'd7;
            default:         c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/lcs_if.sv @@
// lcs_if: valid/ready channel interfaces for events, results and config writes
// depends on lcs_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lcs_evt_if;
    logic                             valid;
    logic                             ready;
    logic [lcs_pkg::KIND_W-1:0]       kind;
    logic [lcs_pkg::NET_W-1:0]        net_id;
    logic signed [lcs_pkg::WORD_W-1:0] err_code;
    logic [lcs_pkg::WORD_W-1:0]       elapsed;

    modport source (output valid, kind, net_id, err_code, elapsed, input ready);
    modport sink   (input valid, kind, net_id, err_code, elapsed, output ready);
endinterface

interface lcs_res_if;
    logic                              valid;
    logic                              ready;
    logic [lcs_pkg::STATUS_W-1:0]      status;
    logic [lcs_pkg::ACTION_W-1:0]      action;
    logic [lcs_pkg::NET_W-1:0]         action_net_id;
    logic [lcs_pkg::MODE_W-1:0]        mode_now;
    logic signed [lcs_pkg::WORD_W-1:0] last_error;
    logic                              transfer_locked;

    modport source (output valid, status, action, action_net_id, mode_now, last_error,
                    transfer_locked, input ready);
    modport sink   (input valid, status, action, action_net_id, mode_now, last_error,
                    transfer_locked, output ready);
endinterface

interface lcs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lcs_pkg::CFG_IDX_W-1:0] index;
    logic [lcs_pkg::WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/lcs_cfg_regs.sv @@
// lcs_cfg_regs: timeout, limit and threshold registers of the link supervisor
// depends on lcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcs_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0] i_idx,
    input  wire logic [lcs_pkg::WORD_W-1:0]    i_data,
    output lcs_pkg::t_cfg                      o_cfg
);

    lcs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_timeout   <= lcs_pkg::STARTUP_TIMEOUT_RST;
            r_cfg.attempt_limit     <= lcs_pkg::ATTEMPT_LIMIT_RST;
            r_cfg.reconnect_timeout <= lcs_pkg::RECONNECT_TIMEOUT_RST;
            r_cfg.probe_interval    <= lcs_pkg::PROBE_INTERVAL_RST;
            r_cfg.fail_threshold    <= lcs_pkg::FAIL_THRESHOLD_RST;
        end else if (i_wr) begin
            // unused indexes fall through and write nothing
            unique case (i_idx)
                lcs_pkg::CFG_STARTUP_TIMEOUT:   r_cfg.startup_timeout <= i_data;
                lcs_pkg::CFG_ATTEMPT_LIMIT:
                    r_cfg.attempt_limit <= i_data[lcs_pkg::COUNT_W-1:0];
                lcs_pkg::CFG_RECONNECT_TIMEOUT: r_cfg.reconnect_timeout <= i_data;
                lcs_pkg::CFG_PROBE_INTERVAL:    r_cfg.probe_interval <= i_data;
                lcs_pkg::CFG_FAIL_THRESHOLD:
                    r_cfg.fail_threshold <= i_data[lcs_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/lcs_engine.sv @@
// lcs_engine: supervisor state registers and the per-event decode
// depends on lcs_pkg; fed from the top level input register
`timescale 1ns / 1ps
`default_nettype none

module lcs_engine (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire lcs_pkg::t_event i_item,
    input  wire lcs_pkg::t_cfg   i_cfg,
    output lcs_pkg::t_result o_res
);

    typedef struct packed {
        lcs_pkg::t_mode                    mode;
        logic [lcs_pkg::NET_W-1:0]         chosen_net;
        logic [lcs_pkg::WORD_W-1:0]        phase_timer;
        logic [lcs_pkg::WORD_W-1:0]        phase_limit;
        logic [lcs_pkg::COUNT_W-1:0]       attempt_count;
        logic [lcs_pkg::WORD_W-1:0]        probe_timer;
        logic [lcs_pkg::COUNT_W-1:0]       fail_count;
        logic signed [lcs_pkg::WORD_W-1:0] error_store;
        logic                              xfer_active;
    } t_state;

    localparam t_state STATE_RST = '{
        mode:          lcs_pkg::MODE_STOPPED,
        chosen_net:    '0,
        phase_timer:   '0,
        phase_limit:   '0,
        attempt_count: '0,
        probe_timer:   '0,
        fail_count:    '0,
        error_store:   '0,
        xfer_active:   1'b0
    };

    t_state r_st;
    t_state n_st;

    lcs_pkg::t_status               w_status;
    lcs_pkg::t_action               w_act;
    logic [lcs_pkg::NET_W-1:0]      w_anet;
    logic [lcs_pkg::WORD_W-1:0]     w_tmr;
    logic [lcs_pkg::WORD_W-1:0]     w_lim;
    logic [lcs_pkg::WORD_W:0]       w_sum;
    logic [lcs_pkg::WORD_W-1:0]     w_tmr_sat;
    logic                           w_tmr_hit;
    logic [lcs_pkg::COUNT_W-1:0]    w_fail_inc;
    logic                           w_ready_mode;

    function automatic t_state enter_mode(input t_state s, input lcs_pkg::t_mode m,
                                          input lcs_pkg::t_cfg c);
        t_state v;
        v = s;
        v.mode = m;
        v.phase_timer = '0;
        if (m != lcs_pkg::MODE_CLIENT) begin
            v.probe_timer = '0;
        end
        if (m == lcs_pkg::MODE_SEARCHING || m == lcs_pkg::MODE_CONNECTING) begin
            v.phase_limit = c.startup_timeout;
        end else if (m == lcs_pkg::MODE_RECONNECT) begin
            v.phase_limit = c.reconnect_timeout;
        end else begin
            v.phase_limit = '0;
        end
        return v;
    endfunction

    function automatic t_state go_hotspot(input t_state s, input lcs_pkg::t_cfg c);
        t_state v;
        v = enter_mode(s, lcs_pkg::MODE_HS_START, c);
        v.chosen_net = '0;
        return v;
    endfunction

    // one shared saturating timer add: probe timer in client mode, phase timer elsewhere
    assign w_tmr = (r_st.mode == lcs_pkg::MODE_CLIENT) ? r_st.probe_timer : r_st.phase_timer;
    assign w_lim = (r_st.mode == lcs_pkg::MODE_CLIENT) ? i_cfg.probe_interval
                                                       : r_st.phase_limit;
    assign w_sum     = {1'b0, w_tmr} + {1'b0, i_item.elapsed};
    assign w_tmr_sat = w_sum[lcs_pkg::WORD_W] ? '1 : w_sum[lcs_pkg::WORD_W-1:0];
    assign w_tmr_hit = (w_tmr_sat >= w_lim);

    assign w_fail_inc = (r_st.fail_count != '1) ? r_st.fail_count + 8'd1 : r_st.fail_count;
    assign w_ready_mode = (r_st.mode == lcs_pkg::MODE_CLIENT)
                       || (r_st.mode == lcs_pkg::MODE_HS_READY);

    always_comb begin
        n_st     = r_st;
        w_status = lcs_pkg::ST_OK;
        w_act    = lcs_pkg::ACT_NONE;
        w_anet   = '0;
        unique case (i_item.kind)
            lcs_pkg::KIND_START: begin
                if (r_st.mode != lcs_pkg::MODE_STOPPED && r_st.mode != lcs_pkg::MODE_FAULTED) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.error_store   = '0;
                    n_st.chosen_net    = '0;
                    n_st.attempt_count = '0;
                    n_st.xfer_active   = 1'b0;
                    n_st  = enter_mode(n_st, lcs_pkg::MODE_SEARCHING, i_cfg);
                    w_act = lcs_pkg::ACT_SCAN;
                end
            end
            lcs_pkg::KIND_SCAN_SEL: begin
                if (i_item.net_id == '0) begin
                    w_status = lcs_pkg::ST_BADARG;
                end else if (r_st.mode != lcs_pkg::MODE_SEARCHING) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.chosen_net    = i_item.net_id;
                    n_st.attempt_count = 8'd1;
                    n_st   = enter_mode(n_st, lcs_pkg::MODE_CONNECTING, i_cfg);
                    w_act  = lcs_pkg::ACT_CONNECT;
                    w_anet = i_item.net_id;
                end
            end
            lcs_pkg::KIND_SCAN_EMPTY: begin
                if (r_st.mode != lcs_pkg::MODE_SEARCHING) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st  = go_hotspot(n_st, i_cfg);
                    w_act = lcs_pkg::ACT_HOTSPOT;
                end
            end
            lcs_pkg::KIND_CONNECTED: begin
                if (r_st.mode != lcs_pkg::MODE_CONNECTING
                        && r_st.mode != lcs_pkg::MODE_RECONNECT) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.error_store = '0;
                    n_st.probe_timer = '0;
                    n_st.fail_count  = '0;
                    n_st = enter_mode(n_st, lcs_pkg::MODE_CLIENT, i_cfg);
                end
            end
            lcs_pkg::KIND_FAILED: begin
                if (r_st.mode != lcs_pkg::MODE_CONNECTING
                        && r_st.mode != lcs_pkg::MODE_RECONNECT) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.error_store = i_item.err_code;
                    // reconnecting rides out a failure without leaving the mode
                    if (r_st.mode == lcs_pkg::MODE_CONNECTING) begin
                        if (r_st.attempt_count < i_cfg.attempt_limit) begin
                            n_st.attempt_count = r_st.attempt_count + 8'd1;
                            n_st   = enter_mode(n_st, lcs_pkg::MODE_CONNECTING, i_cfg);
                            w_act  = lcs_pkg::ACT_RECOVER;
                            w_anet = r_st.chosen_net;
                        end else begin
                            n_st  = go_hotspot(n_st, i_cfg);
                            w_act = lcs_pkg::ACT_HOTSPOT;
                        end
                    end
                end
            end
            lcs_pkg::KIND_LOST: begin
                if (r_st.mode != lcs_pkg::MODE_CLIENT || r_st.chosen_net == '0) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.error_store = i_item.err_code;
                    n_st   = enter_mode(n_st, lcs_pkg::MODE_RECONNECT, i_cfg);
                    w_act  = lcs_pkg::ACT_CONNECT;
                    w_anet = r_st.chosen_net;
                end
            end
            lcs_pkg::KIND_HEALTHY: begin
                if (r_st.mode != lcs_pkg::MODE_CLIENT) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.error_store = '0;
                    n_st.fail_count  = '0;
                end
            end
            lcs_pkg::KIND_UNHEALTHY: begin
                if (r_st.mode != lcs_pkg::MODE_CLIENT) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else if (r_st.xfer_active) begin
                    w_status = lcs_pkg::ST_LOCKED;
                end else begin
                    n_st.error_store = i_item.err_code;
                    n_st.fail_count  = w_fail_inc;
                    if (w_fail_inc >= i_cfg.fail_threshold) begin
                        n_st   = enter_mode(n_st, lcs_pkg::MODE_RECONNECT, i_cfg);
                        w_act  = lcs_pkg::ACT_RECOVER;
                        w_anet = r_st.chosen_net;
                    end
                end
            end
            lcs_pkg::KIND_HS_UP: begin
                if (r_st.mode != lcs_pkg::MODE_HS_START) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.error_store = '0;
                    n_st = enter_mode(n_st, lcs_pkg::MODE_HS_READY, i_cfg);
                end
            end
            lcs_pkg::KIND_HS_FAIL: begin
                if (r_st.mode != lcs_pkg::MODE_HS_START) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.error_store = i_item.err_code;
                    n_st = enter_mode(n_st, lcs_pkg::MODE_FAULTED, i_cfg);
                end
            end
            lcs_pkg::KIND_RETRY: begin
                if (!w_ready_mode) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else if (r_st.xfer_active) begin
                    w_status = lcs_pkg::ST_LOCKED;
                end else begin
                    n_st.error_store = '0;
                    n_st.chosen_net  = '0;
                    n_st  = enter_mode(n_st, lcs_pkg::MODE_SEARCHING, i_cfg);
                    w_act = lcs_pkg::ACT_SCAN;
                end
            end
            lcs_pkg::KIND_FORCE_HS: begin
                if (r_st.mode == lcs_pkg::MODE_STOPPED || r_st.mode == lcs_pkg::MODE_HS_START
                        || r_st.mode == lcs_pkg::MODE_HS_READY) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else if (r_st.xfer_active) begin
                    w_status = lcs_pkg::ST_LOCKED;
                end else begin
                    n_st  = go_hotspot(n_st, i_cfg);
                    w_act = lcs_pkg::ACT_HOTSPOT;
                end
            end
            lcs_pkg::KIND_XFER_START: begin
                if (!w_ready_mode || r_st.xfer_active) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.xfer_active = 1'b1;
                end
            end
            lcs_pkg::KIND_XFER_END: begin
                if (!r_st.xfer_active) begin
                    w_status = lcs_pkg::ST_BADSTATE;
                end else begin
                    n_st.xfer_active = 1'b0;
                end
            end
            lcs_pkg::KIND_TICK: begin
                if (i_item.elapsed == '0) begin
                    w_status = lcs_pkg::ST_BADARG;
                end else if (r_st.mode == lcs_pkg::MODE_CLIENT) begin
                    // an active transfer holds off probing
                    if (r_st.xfer_active || w_tmr_hit) begin
                        n_st.probe_timer = '0;
                    end else begin
                        n_st.probe_timer = w_tmr_sat;
                    end
                    if (!r_st.xfer_active && w_tmr_hit) begin
                        w_act  = lcs_pkg::ACT_PROBE;
                        w_anet = r_st.chosen_net;
                    end
                end else if (r_st.mode == lcs_pkg::MODE_SEARCHING
                        || r_st.mode == lcs_pkg::MODE_CONNECTING
                        || r_st.mode == lcs_pkg::MODE_RECONNECT) begin
                    n_st.phase_timer = w_tmr_sat;
                    if (w_tmr_hit) begin
                        n_st  = go_hotspot(n_st, i_cfg);
                        w_act = lcs_pkg::ACT_HOTSPOT;
                    end
                end
            end
            lcs_pkg::KIND_STOP: begin
                n_st  = STATE_RST;
                w_act = lcs_pkg::ACT_STOP;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RST;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    assign o_res.status          = w_status;
    assign o_res.action          = w_act;
    assign o_res.action_net_id   = w_anet;
    assign o_res.mode_now        = lcs_pkg::mode_code(n_st.mode);
    assign o_res.last_error      = n_st.error_store;
    assign o_res.transfer_locked = n_st.xfer_active;

endmodule

`default_nettype wire

@@ sv/link_connection_supervisor_top.sv @@
// link_connection_supervisor_top: event register, supervisor engine, result register
// depends on lcs_pkg, lcs_if, lcs_cfg_regs, lcs_engine
//
//   port    dir   handshake     carries
//   i_evt   in    valid/ready   kind, net_id, err_code, elapsed
//   o_res   out   valid/ready   status, action, action_net_id, mode_now,
//                               last_error, transfer_locked
//   i_cfg   in    valid/ready   index, data (register write, always ready)
//
// one event per cycle sustained while the result side keeps ready high; each taken event
// is loaded into the event register, and its result then into the result register
// the engine decode and one saturating 32-bit timer add sit between the two registers
// reset is synchronous and active low; no clearing pass is needed
// a stalled result holds the result register; the event register keeps taking
// items until both registers are full
`timescale 1ns / 1ps
`default_nettype none

module link_connection_supervisor_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lcs_cfg_if.sink    i_cfg,
    lcs_evt_if.sink    i_evt,
    lcs_res_if.source  o_res
);

    lcs_pkg::t_cfg    w_cfg;
    lcs_pkg::t_result w_res;
    logic             w_out_load;
    logic             w_fire;
    logic             w_in_take;

    logic             r_in_valid;
    lcs_pkg::t_event  r_in_item;
    logic             r_out_valid;
    lcs_pkg::t_result r_out_res;

    assign i_cfg.ready = 1'b1;

    lcs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    assign w_out_load  = !r_out_valid || o_res.ready;
    assign w_fire      = r_in_valid && w_out_load;
    assign i_evt.ready = !r_in_valid || w_fire;
    assign w_in_take   = i_evt.valid && i_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item.kind     <= lcs_pkg::t_kind'(i_evt.kind);
            r_in_item.net_id   <= i_evt.net_id;
            r_in_item.err_code <= i_evt.err_code;
            r_in_item.elapsed  <= i_evt.elapsed;
        end
    end

    lcs_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_res <= w_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out_res.status;
    assign o_res.action          = r_out_res.action;
    assign o_res.action_net_id   = r_out_res.action_net_id;
    assign o_res.mode_now        = r_out_res.mode_now;
    assign o_res.last_error      = r_out_res.last_error;
    assign o_res.transfer_locked = r_out_res.transfer_locked;

endmodule

`default_nettype wire

@@ sim/link_connection_supervisor_top_test.sv @@
// link_connection_supervisor_top_test: self-checking bench for the link supervisor top level
// a scoreboard class predicts every result from each accepted event item; plain tasks drive
// depends on lcs_pkg, lcs_if and link_connection_supervisor_top
`timescale 1ns / 1ps

module link_connection_supervisor_top_test;
    import lcs_pkg::*;

    localparam int unsigned RX_HOLD_CYCLES  = 300;
    localparam int unsigned ITEMS_PER_PHASE = 250;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned REPORT_LIMIT    = 10;

    // mode codes as they appear on mode_now
    typedef enum logic [MODE_W-1:0] {
        LINK_STOPPED,
        LINK_SEARCHING,
        LINK_CONNECTING,
        LINK_CLIENT,
        LINK_RECONNECT,
        LINK_HS_START,
        LINK_HS_READY,
        LINK_FAULTED
    } t_link_mode;

    class link_scoreboard;
        logic [WORD_W-1:0]        startup_timeout;
        logic [COUNT_W-1:0]       attempt_limit;
        logic [WORD_W-1:0]        reconnect_timeout;
        logic [WORD_W-1:0]        probe_interval;
        logic [COUNT_W-1:0]       fail_threshold;

        t_link_mode               mode;
        logic [NET_W-1:0]         chosen_net;
        logic [WORD_W-1:0]        phase_timer;
        logic [WORD_W-1:0]        phase_limit;
        logic [WORD_W-1:0]        probe_timer;
        logic [COUNT_W-1:0]       attempt_count;
        logic [COUNT_W-1:0]       fail_count;
        logic signed [WORD_W-1:0] error_store;
        logic                     xfer_active;

        t_result                  due_outcomes[$];
        int unsigned              mismatches;
        int unsigned              outcomes_seen;

        function new();
            startup_timeout   = STARTUP_TIMEOUT_RST;
            attempt_limit     = ATTEMPT_LIMIT_RST;
            reconnect_timeout = RECONNECT_TIMEOUT_RST;
            probe_interval    = PROBE_INTERVAL_RST;
            fail_threshold    = FAIL_THRESHOLD_RST;
            clear_link();
            mismatches    = 0;
            outcomes_seen = 0;
        endfunction

        function void clear_link();
            mode          = LINK_STOPPED;
            chosen_net    = '0;
            phase_timer   = '0;
            phase_limit   = '0;
            probe_timer   = '0;
            attempt_count = '0;
            fail_count    = '0;
            error_store   = '0;
            xfer_active   = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] d);
            case (idx)
                CFG_STARTUP_TIMEOUT:   startup_timeout   = d;
                CFG_ATTEMPT_LIMIT:     attempt_limit     = d[COUNT_W-1:0];
                CFG_RECONNECT_TIMEOUT: reconnect_timeout = d;
                CFG_PROBE_INTERVAL:    probe_interval    = d;
                CFG_FAIL_THRESHOLD:    fail_threshold    = d[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void enter(t_link_mode m);
            mode        = m;
            phase_timer = '0;
            if (m != LINK_CLIENT)
                probe_timer = '0;
            if (m == LINK_SEARCHING || m == LINK_CONNECTING)
                phase_limit = startup_timeout;
            else if (m == LINK_RECONNECT)
                phase_limit = reconnect_timeout;
            else
                phase_limit = '0;
        endfunction

        function t_action to_hotspot();
            enter(LINK_HS_START);
            chosen_net = '0;
            return ACT_HOTSPOT;
        endfunction

        function logic [WORD_W-1:0] sat_add(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
            logic [WORD_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[WORD_W] ? '1 : s[WORD_W-1:0];
        endfunction

        // rejected events return before touching any state
        function t_status supervise(t_event ev, output t_action act,
                                    output logic [NET_W-1:0] anet);
            logic ready_mode;
            act = ACT_NONE;
            anet = '0;
            ready_mode = (mode == LINK_CLIENT) || (mode == LINK_HS_READY);
            case (ev.kind)
                KIND_START: begin
                    if (mode != LINK_STOPPED && mode != LINK_FAULTED)
                        return ST_BADSTATE;
                    error_store   = '0;
                    chosen_net    = '0;
                    attempt_count = '0;
                    xfer_active   = 1'b0;
                    enter(LINK_SEARCHING);
                    act = ACT_SCAN;
                end
                KIND_SCAN_SEL: begin
                    if (ev.net_id == '0)
                        return ST_BADARG;
                    if (mode != LINK_SEARCHING)
                        return ST_BADSTATE;
                    chosen_net    = ev.net_id;
                    attempt_count = 8'd1;
                    enter(LINK_CONNECTING);
                    act  = ACT_CONNECT;
                    anet = ev.net_id;
                end
                KIND_SCAN_EMPTY: begin
                    if (mode != LINK_SEARCHING)
                        return ST_BADSTATE;
                    act = to_hotspot();
                end
                KIND_CONNECTED: begin
                    if (mode != LINK_CONNECTING && mode != LINK_RECONNECT)
                        return ST_BADSTATE;
                    error_store = '0;
                    probe_timer = '0;
                    fail_count  = '0;
                    enter(LINK_CLIENT);
                end
                KIND_FAILED: begin
                    if (mode != LINK_CONNECTING && mode != LINK_RECONNECT)
                        return ST_BADSTATE;
                    error_store = ev.err_code;
                    // reconnecting rides out a failure without leaving the mode
                    if (mode == LINK_RECONNECT)
                        return ST_OK;
                    if (attempt_count < attempt_limit) begin
                        attempt_count = attempt_count + 8'd1;
                        enter(LINK_CONNECTING);
                        act  = ACT_RECOVER;
                        anet = chosen_net;
                    end else begin
                        act = to_hotspot();
                    end
                end
                KIND_LOST: begin
                    if (mode != LINK_CLIENT || chosen_net == '0)
                        return ST_BADSTATE;
                    error_store = ev.err_code;
                    enter(LINK_RECONNECT);
                    act  = ACT_CONNECT;
                    anet = chosen_net;
                end
                KIND_HEALTHY: begin
                    if (mode != LINK_CLIENT)
                        return ST_BADSTATE;
                    error_store = '0;
                    fail_count  = '0;
                end
                KIND_UNHEALTHY: begin
                    if (mode != LINK_CLIENT)
                        return ST_BADSTATE;
                    if (xfer_active)
                        return ST_LOCKED;
                    error_store = ev.err_code;
                    if (fail_count != 8'hFF)
                        fail_count = fail_count + 8'd1;
                    if (fail_count >= fail_threshold) begin
                        enter(LINK_RECONNECT);
                        act  = ACT_RECOVER;
                        anet = chosen_net;
                    end
                end
                KIND_HS_UP: begin
                    if (mode != LINK_HS_START)
                        return ST_BADSTATE;
                    error_store = '0;
                    enter(LINK_HS_READY);
                end
                KIND_HS_FAIL: begin
                    if (mode != LINK_HS_START)
                        return ST_BADSTATE;
                    error_store = ev.err_code;
                    enter(LINK_FAULTED);
                end
                KIND_RETRY: begin
                    if (!ready_mode)
                        return ST_BADSTATE;
                    if (xfer_active)
                        return ST_LOCKED;
                    error_store = '0;
                    chosen_net  = '0;
                    enter(LINK_SEARCHING);
                    act = ACT_SCAN;
                end
                KIND_FORCE_HS: begin
                    if (mode == LINK_STOPPED || mode == LINK_HS_START || mode == LINK_HS_READY)
                        return ST_BADSTATE;
                    if (xfer_active)
                        return ST_LOCKED;
                    act = to_hotspot();
                end
                KIND_XFER_START: begin
                    if (!ready_mode || xfer_active)
                        return ST_BADSTATE;
                    xfer_active = 1'b1;
                end
                KIND_XFER_END: begin
                    if (!xfer_active)
                        return ST_BADSTATE;
                    xfer_active = 1'b0;
                end
                KIND_TICK: begin
                    if (ev.elapsed == '0)
                        return ST_BADARG;
                    if (mode == LINK_CLIENT) begin
                        // an active transfer keeps the probe timer parked at zero
                        if (xfer_active) begin
                            probe_timer = '0;
                        end else begin
                            probe_timer = sat_add(probe_timer, ev.elapsed);
                            if (probe_timer >= probe_interval) begin
                                probe_timer = '0;
                                act  = ACT_PROBE;
                                anet = chosen_net;
                            end
                        end
                    end else if (mode == LINK_SEARCHING || mode == LINK_CONNECTING ||
                                 mode == LINK_RECONNECT) begin
                        phase_timer = sat_add(phase_timer, ev.elapsed);
                        if (phase_timer >= phase_limit)
                            act = to_hotspot();
                    end
                end
                default: begin
                    clear_link();
                    act = ACT_STOP;
                end
            endcase
            return ST_OK;
        endfunction

        function void take_event(t_event ev);
            t_result          r;
            t_action          act;
            logic [NET_W-1:0] anet;
            t_status          st;
            st = supervise(ev, act, anet);
            if (st != ST_OK) begin
                act  = ACT_NONE;
                anet = '0;
            end
            r.status          = st;
            r.action          = act;
            r.action_net_id   = anet;
            r.mode_now        = mode;
            r.last_error      = error_store;
            r.transfer_locked = xfer_active;
            due_outcomes.push_back(r);
        endfunction

        function void match_outcome(t_result got);
            t_result want;
            outcomes_seen++;
            if (due_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("outcome %0d arrived with nothing predicted", outcomes_seen);
                return;
            end
            want = due_outcomes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("outcome %0d: expected st %0d act %0d net %h mode %0d err %h lock %b",
                             outcomes_seen, want.status, want.action, want.action_net_id,
                             want.mode_now, want.last_error, want.transfer_locked);
                    $display("outcome %0d: got      st %0d act %0d net %h mode %0d err %h lock %b",
                             outcomes_seen, got.status, got.action, got.action_net_id,
                             got.mode_now, got.last_error, got.transfer_locked);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lcs_evt_if evt_if ();
    lcs_res_if res_if ();
    lcs_cfg_if cfg_if ();

    link_connection_supervisor_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_evt   (evt_if),
        .o_res   (res_if)
    );

    link_scoreboard sb;
    int unsigned    rx_left;
    bit             rx_hold_req;
    bit             no_idle;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // far beyond the slowest legal run
    initial begin
        #(6_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // mostly back to back, some short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // result side: sample before this edge's updates, then pick the next ready level
    always @(posedge clk) begin : rx_side
        t_result     got;
        int unsigned gap;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.status          = t_status'(res_if.status);
            got.action          = t_action'(res_if.action);
            got.action_net_id   = res_if.action_net_id;
            got.mode_now        = res_if.mode_now;
            got.last_error      = res_if.last_error;
            got.transfer_locked = res_if.transfer_locked;
            sb.match_outcome(got);
        end
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_left = RX_HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (rx_left != 0) begin
            rx_left--;
        end else begin
            gap = pick_gap();
            if (gap == 0) begin
                res_if.ready <= 1'b1;
                rx_left = $urandom_range(0, 6);
            end else begin
                res_if.ready <= 1'b0;
                rx_left = gap - 1;
            end
        end
    end

    function automatic t_event mk(t_kind k, logic [NET_W-1:0] n, logic [WORD_W-1:0] e,
                                  logic [WORD_W-1:0] el);
        t_event ev;
        ev.kind     = k;
        ev.net_id   = n;
        ev.err_code = e;
        ev.elapsed  = el;
        return ev;
    endfunction

    // mostly events that suit the current mode, so that runs reach the deep modes
    function automatic t_event next_event();
        t_event            ev;
        t_kind             pool[$];
        int unsigned       r;
        logic [WORD_W-1:0] span;
        case (sb.mode)
            LINK_SEARCHING:
                pool = '{KIND_SCAN_SEL, KIND_SCAN_SEL, KIND_SCAN_SEL, KIND_SCAN_SEL, KIND_SCAN_SEL,
                         KIND_SCAN_EMPTY, KIND_TICK, KIND_TICK, KIND_FORCE_HS};
            LINK_CONNECTING:
                pool = '{KIND_CONNECTED, KIND_CONNECTED, KIND_CONNECTED, KIND_FAILED, KIND_FAILED,
                         KIND_FAILED, KIND_TICK, KIND_TICK, KIND_FORCE_HS, KIND_LOST};
            LINK_CLIENT:
                pool = '{KIND_HEALTHY, KIND_HEALTHY, KIND_UNHEALTHY, KIND_UNHEALTHY,
                         KIND_UNHEALTHY, KIND_UNHEALTHY, KIND_LOST, KIND_LOST, KIND_TICK,
                         KIND_TICK, KIND_TICK, KIND_XFER_START, KIND_XFER_START,
                         KIND_XFER_END, KIND_XFER_END, KIND_RETRY, KIND_FORCE_HS};
            LINK_RECONNECT:
                pool = '{KIND_CONNECTED, KIND_CONNECTED, KIND_FAILED, KIND_FAILED, KIND_TICK,
                         KIND_TICK, KIND_FORCE_HS, KIND_UNHEALTHY};
            LINK_HS_START:
                pool = '{KIND_HS_UP, KIND_HS_UP, KIND_HS_UP, KIND_HS_FAIL, KIND_FORCE_HS,
                         KIND_TICK};
            LINK_HS_READY:
                pool = '{KIND_RETRY, KIND_RETRY, KIND_XFER_START, KIND_XFER_START,
                         KIND_XFER_END, KIND_XFER_END, KIND_TICK, KIND_TICK, KIND_FORCE_HS};
            LINK_FAULTED:
                pool = '{KIND_START, KIND_START, KIND_START, KIND_FORCE_HS, KIND_FORCE_HS,
                         KIND_TICK, KIND_RETRY};
            default:
                pool = '{KIND_START, KIND_START, KIND_START, KIND_START, KIND_TICK,
                         KIND_FORCE_HS, KIND_SCAN_SEL, KIND_STOP};
        endcase
        r = $urandom_range(0, 99);
        if (r < 2)
            ev.kind = KIND_STOP;
        else if (r < 14)
            ev.kind = t_kind'($urandom_range(0, 15));
        else
            ev.kind = pool[$urandom_range(0, pool.size() - 1)];

        r = $urandom_range(0, 99);
        if (r < 5)
            ev.net_id = '0;
        else if (r < 10)
            ev.net_id = '1;
        else
            ev.net_id = NET_W'($urandom_range(1, 65535));

        r = $urandom_range(0, 99);
        if (r < 10)
            ev.err_code = '0;
        else if (r < 15)
            ev.err_code = 32'h8000_0000;
        else if (r < 20)
            ev.err_code = 32'h7FFF_FFFF;
        else
            ev.err_code = $urandom;

        // tick sizes scaled to the timer that the current mode runs
        case (sb.mode)
            LINK_CLIENT:    span = sb.probe_interval;
            LINK_RECONNECT: span = sb.reconnect_timeout;
            default:        span = sb.startup_timeout;
        endcase
        r = $urandom_range(0, 99);
        if (r < 4)
            ev.elapsed = '0;
        else if (r < 8)
            ev.elapsed = '1;
        else if (r < 16)
            ev.elapsed = $urandom;
        else
            ev.elapsed = $urandom_range(1, span / 4 + 1);
        return ev;
    endfunction

    task automatic offer(t_event ev);
        int unsigned g;
        evt_if.valid    <= 1'b1;
        evt_if.kind     <= ev.kind;
        evt_if.net_id   <= ev.net_id;
        evt_if.err_code <= ev.err_code;
        evt_if.elapsed  <= ev.elapsed;
        do @(posedge clk); while (!evt_if.ready);
        sb.take_event(ev);
        g = pick_gap();
        if (g != 0) begin
            evt_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // stop offering and wait for every predicted result
    task automatic drain();
        evt_if.valid <= 1'b0;
        do @(posedge clk); while (sb.due_outcomes.size() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge clk); while (!cfg_if.ready);
        sb.write_reg(idx, d);
    endtask

    task automatic program_regs(bit with_spare, logic [WORD_W-1:0] st, logic [COUNT_W-1:0] al,
                                logic [WORD_W-1:0] rt, logic [WORD_W-1:0] pi,
                                logic [COUNT_W-1:0] ft);
        if (with_spare)
            for (int unsigned ix = CFG_FAIL_THRESHOLD + 1; ix < 2 ** CFG_IDX_W; ix++)
                cfg_write(ix[CFG_IDX_W-1:0], $urandom);
        cfg_write(CFG_STARTUP_TIMEOUT, st);
        cfg_write(CFG_ATTEMPT_LIMIT, {24'($urandom), al});
        cfg_write(CFG_RECONNECT_TIMEOUT, rt);
        cfg_write(CFG_PROBE_INTERVAL, pi);
        cfg_write(CFG_FAIL_THRESHOLD, {24'($urandom), ft});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_phase(int unsigned count, bit squeeze);
        for (int unsigned n = 0; n < count; n++) begin
            if (n == count / 3)
                drain();
            // result side shuts for a long stretch while items keep coming
            if (squeeze && n == count / 2)
                rx_hold_req = 1'b1;
            offer(next_event());
        end
    endtask

    initial begin
        sb = new();
        rst_n           = 1'b0;
        no_idle         = 1'b0;
        rx_hold_req     = 1'b0;
        rx_left         = 0;
        evt_if.valid    = 1'b0;
        evt_if.kind     = '0;
        evt_if.net_id   = '0;
        evt_if.err_code = '0;
        evt_if.elapsed  = '0;
        res_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through every mode at reset settings
        offer(mk(KIND_STOP,        16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_TICK,        16'h1234, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_SCAN_SEL,    16'h0000, 32'h0000_0000, 32'h0000_0001));
        offer(mk(KIND_START,       16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_SCAN_SEL,    16'hFFFF, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_FAILED,      16'h0000, 32'h8000_0000, 32'h0000_0000));
        offer(mk(KIND_FAILED,      16'h0000, 32'h7FFF_FFFF, 32'h0000_0000));
        offer(mk(KIND_TICK,        16'h0000, 32'h0000_0000, 32'hFFFF_FFFF));
        offer(mk(KIND_HS_UP,       16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_TICK,        16'h0000, 32'h0000_0000, 32'h0000_0001));
        offer(mk(KIND_XFER_START,  16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_RETRY,       16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_XFER_END,    16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_RETRY,       16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_SCAN_SEL,    16'h0001, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_CONNECTED,   16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_HEALTHY,     16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_XFER_START,  16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_TICK,        16'h0000, 32'h0000_0000, 32'd6000));
        offer(mk(KIND_UNHEALTHY,   16'h0000, 32'hDEAD_BEEF, 32'h0000_0000));
        offer(mk(KIND_XFER_END,    16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_TICK,        16'h0000, 32'h0000_0000, 32'hFFFF_FFFF));
        offer(mk(KIND_LOST,        16'h0000, 32'hFFFF_FFFF, 32'h0000_0000));
        offer(mk(KIND_FAILED,      16'h0000, 32'h0000_0005, 32'h0000_0000));
        offer(mk(KIND_FORCE_HS,    16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_HS_FAIL,     16'h0000, 32'h1234_5678, 32'h0000_0000));
        offer(mk(KIND_START,       16'h0000, 32'h0000_0000, 32'h0000_0000));
        offer(mk(KIND_SCAN_EMPTY,  16'h0000, 32'h0000_0000, 32'h0000_0000));

        // smallest legal settings, spare indexes written too
        drain();
        program_regs(1'b1, 32'd1, 8'd1, 32'd1, 32'd1, 8'd1);
        run_phase(ITEMS_PER_PHASE, 1'b0);

        // largest settings: timeouts only reached by saturation
        drain();
        program_regs(1'b0, '1, 8'hFF, '1, '1, 8'hFF);
        run_phase(ITEMS_PER_PHASE, 1'b1);

        // all zero: every limit is met at once
        drain();
        program_regs(1'b0, '0, '0, '0, '0, '0);
        run_phase(ITEMS_PER_PHASE, 1'b0);

        for (int k = 0; k < 4; k++) begin
            drain();
            program_regs(1'b0, $urandom_range(1, 4000), COUNT_W'($urandom_range(1, 6)),
                         $urandom_range(1, 8000), $urandom_range(1, 3000),
                         COUNT_W'($urandom_range(1, 6)));
            no_idle = (k == 1);
            run_phase(ITEMS_PER_PHASE, k == 2);
            no_idle = 1'b0;
        end

        drain();
        program_regs(1'b0, STARTUP_TIMEOUT_RST, ATTEMPT_LIMIT_RST, RECONNECT_TIMEOUT_RST,
                     PROBE_INTERVAL_RST, FAIL_THRESHOLD_RST);
        run_phase(ITEMS_PER_PHASE, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.due_outcomes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
sv/lcs_pkg.sv
sv/lcs_if.sv
sv/lcs_cfg_regs.sv
sv/lcs_engine.sv
sv/link_connection_supervisor_top.sv
sim/link_connection_supervisor_top_test.sv
